// ===== rtl/generation_tagged_two_way_cache_core_defines.svh =====
// Assertion macros shared by the cache core RTL.
// Depends on nothing; included by the top level only.
`ifndef GENERATION_TAGGED_TWO_WAY_CACHE_CORE_DEFINES_SVH
`define GENERATION_TAGGED_TWO_WAY_CACHE_CORE_DEFINES_SVH

// Condition must never be true while out of reset.
`define GTC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

// Antecedent true implies consequent true in the same cycle.
`define GTC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

`endif

// ===== rtl/gtc_pkg.sv =====
// Shared types and constants for the generation-tagged cache core.
// No dependencies; imported by every module of the core.
`default_nettype none

package gtc_pkg;

    // Hash multipliers
    localparam logic [31:0] HASH_OBJ_MUL = 32'd2654435761;
    localparam logic [31:0] HASH_IDX_MUL = 32'd2246822519;

    // Item kinds
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_FILL   = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // Widest set and way indexes the parameter ranges allow
    localparam int SET_IDX_MAX_W = 16;
    localparam int WAY_IDX_MAX_W = 3;

    // Classified operation passed from front to back
    typedef struct packed {
        logic [1:0]               kind;
        logic [31:0]              object_key;
        logic [31:0]              index_key;
        logic [31:0]              fill_descriptor;
        logic [SET_IDX_MAX_W-1:0] set_idx;
        logic [WAY_IDX_MAX_W-1:0] way_idx;
    } gtc_op_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } gtc_q_stat_t;

    // One cache entry
    typedef struct packed {
        logic [31:0] gen;
        logic [31:0] object_key;
        logic [31:0] index_key;
        logic [31:0] descriptor;
    } gtc_entry_t;

endpackage

`default_nettype wire

// ===== rtl/gtc_front.sv =====
// Front end: accepts input beats, hashes the key and picks set and victim way.
// Depends on gtc_pkg; pushes operations into gtc_queue.
`default_nettype none

module gtc_front #(
    parameter int SET_COUNT = 8192,
    parameter int WAY_COUNT = 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_kind,
    input  wire logic [31:0]          s_object_key,
    input  wire logic [31:0]          s_index_key,
    input  wire logic [31:0]          s_fill_descriptor,
    input  wire logic                 clear_busy,
    input  wire gtc_pkg::gtc_q_stat_t q_stat,
    output logic                      q_push,
    output gtc_pkg::gtc_op_t          q_op
);
    import gtc_pkg::*;

    localparam int SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int WAY_W  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int SETR_W = SET_W + 1;
    localparam int WAYR_W = WAY_W + 1;
    localparam logic [SETR_W-1:0] SET_C = SETR_W'(SET_COUNT);
    localparam logic [WAYR_W-1:0] WAY_C = WAYR_W'(WAY_COUNT);
    localparam bit SET_POW2 = ((SET_COUNT & (SET_COUNT - 1)) == 0);
    localparam bit WAY_POW2 = ((WAY_COUNT & (WAY_COUNT - 1)) == 0);
    localparam bit NEED_REM = !(SET_POW2 && WAY_POW2);

    // Remainder steps: reciprocal multiply, back-multiply and subtract, final correction
    localparam int REM_STEPS = 3;
    localparam logic [4:0] REM_MUL  = 5'd0;
    localparam logic [4:0] REM_SUB  = 5'd1;
    localparam logic [4:0] REM_LAST = 5'(REM_STEPS - 1);

    // Truncated reciprocals; the quotient estimate is low by at most one
    localparam longint SET_RECIP = (longint'(1) << 24) / SET_COUNT;
    localparam longint WAY_RECIP = (longint'(1) << 30) / WAY_COUNT;
    localparam logic [24:0] SET_M = 25'(SET_RECIP);
    localparam logic [30:0] WAY_M = 31'(WAY_RECIP);
    localparam logic [23:0] SET_D = 24'(SET_COUNT);
    localparam logic [29:0] WAY_D = 30'(WAY_COUNT);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HASH = 2'd1;
    localparam logic [1:0] F_REM  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  kind_reg;
    logic [31:0] obj_reg, idx_reg, fill_reg;
    logic [31:0] pobj_reg, pidx_reg;
    logic [SET_W-1:0] set_reg;
    logic [WAY_W-1:0] way_reg;
    logic [23:0] x_set_reg, q_set_reg;
    logic [29:0] x_way_reg, q_way_reg;
    logic [SETR_W-1:0] rem_set_reg;
    logic [WAYR_W-1:0] rem_way_reg;

    logic        accept;
    logic [31:0] pobj_next, pidx_next;
    logic [31:0] h_mix, h_fold;
    logic [23:0] h_set;
    logic [SET_W-1:0]  set_mask;
    logic [WAY_W-1:0]  way_mask;
    logic [48:0] set_prod;
    logic [60:0] way_prod;
    logic [23:0] set_qd, set_est;
    logic [29:0] way_qd, way_est;
    logic [SET_W-1:0]  set_fix;
    logic [WAY_W-1:0]  way_fix;

    assign s_ready = (state_reg == F_IDLE) && !clear_busy;
    assign accept  = s_valid && s_ready;

    // Products are registered before the fold
    assign pobj_next = (s_object_key >> 4) * HASH_OBJ_MUL;
    assign pidx_next = s_index_key * HASH_IDX_MUL;

    // Hash fold and power-of-two reductions
    assign h_mix    = pobj_reg ^ pidx_reg;
    assign h_fold   = h_mix ^ (h_mix >> 15);
    assign h_set    = h_fold[31:8];
    assign set_mask = SET_W'(h_set & 24'(SET_COUNT - 1));
    assign way_mask = WAY_W'(obj_reg[31:2] & 30'(WAY_COUNT - 1));

    // Remainder by reciprocal multiplication, one registered step per cycle
    assign set_prod = 49'(x_set_reg) * 49'(SET_M);
    assign way_prod = 61'(x_way_reg) * 61'(WAY_M);
    assign set_qd   = q_set_reg * SET_D;
    assign way_qd   = q_way_reg * WAY_D;
    assign set_est  = x_set_reg - set_qd;
    assign way_est  = x_way_reg - way_qd;
    assign set_fix  = (rem_set_reg >= SET_C) ? SET_W'(rem_set_reg - SET_C)
                                             : SET_W'(rem_set_reg);
    assign way_fix  = (rem_way_reg >= WAY_C) ? WAY_W'(rem_way_reg - WAY_C)
                                             : WAY_W'(rem_way_reg);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        q_push     = 1'b0;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_HASH;
                end
            end
            F_HASH: begin
                cnt_next   = '0;
                state_next = NEED_REM ? F_REM : F_PUSH;
            end
            F_REM: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == REM_LAST) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!q_stat.full) begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_kind;
            obj_reg  <= s_object_key;
            idx_reg  <= s_index_key;
            fill_reg <= s_fill_descriptor;
            pobj_reg <= pobj_next;
            pidx_reg <= pidx_next;
        end
        if (state_reg == F_HASH) begin
            set_reg   <= set_mask;
            way_reg   <= way_mask;
            x_set_reg <= h_set;
            x_way_reg <= obj_reg[31:2];
        end
        if (state_reg == F_REM) begin
            if (cnt_reg == REM_MUL) begin
                q_set_reg <= set_prod[47:24];
                q_way_reg <= way_prod[59:30];
            end
            if (cnt_reg == REM_SUB) begin
                rem_set_reg <= SETR_W'(set_est);
                rem_way_reg <= WAYR_W'(way_est);
            end
            if (cnt_reg == REM_LAST) begin
                set_reg <= set_fix;
                way_reg <= way_fix;
            end
        end
    end

    assign q_op.kind            = kind_reg;
    assign q_op.object_key      = obj_reg;
    assign q_op.index_key       = idx_reg;
    assign q_op.fill_descriptor = fill_reg;
    assign q_op.set_idx         = SET_IDX_MAX_W'(set_reg);
    assign q_op.way_idx         = WAY_IDX_MAX_W'(way_reg);

endmodule

`default_nettype wire

// ===== rtl/gtc_queue.sv =====
// Two-entry queue of classified operations between front and back.
// Depends on gtc_pkg.
`default_nettype none

module gtc_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire gtc_pkg::gtc_op_t     push_op,
    input  wire logic                 pop,
    output gtc_pkg::gtc_op_t          head_op,
    output gtc_pkg::gtc_q_stat_t      stat
);
    import gtc_pkg::*;

    localparam int DEPTH = 2;

    gtc_op_t    slot_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == 2'(DEPTH));
    assign stat.empty = (cnt_reg == 2'd0);
    assign head_op    = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gtc_back.sv =====
// Back end: entry memories, clearing pass, frame generation, tag compare,
// fill and the result register. Depends on gtc_pkg; pops from gtc_queue.
`default_nettype none

module gtc_back #(
    parameter int SET_COUNT = 8192,
    parameter int WAY_COUNT = 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire gtc_pkg::gtc_q_stat_t q_stat,
    input  wire gtc_pkg::gtc_op_t     q_head,
    output logic                      q_pop,
    output logic                      clear_busy,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_hit,
    output logic [31:0]               m_descriptor_out,
    output logic                      m_displaced
);
    import gtc_pkg::*;

    localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int WAY_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam logic [SET_W-1:0] SET_LAST = SET_W'(SET_COUNT - 1);

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_EXEC  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [31:0]      frame_gen_reg, frame_gen_next;
    gtc_op_t          op_reg;
    logic             m_valid_reg, m_valid_next;
    logic             m_hit_reg;
    logic [31:0]      m_desc_reg;
    logic             m_disp_reg;

    logic             out_free, head_mem, head_other, exec;
    logic [SET_W-1:0] rd_addr, wr_addr;
    gtc_entry_t       wr_data;
    gtc_entry_t       rd_data [WAY_COUNT];
    logic [WAY_COUNT-1:0] live, match, wr_en;
    logic             hit_any, all_live;
    logic [31:0]      hit_desc;
    logic [WAY_W-1:0] pick;
    logic [31:0]      gen_inc;

    assign clear_busy = (state_reg == B_CLEAR);
    assign out_free   = !m_valid_reg || m_ready;
    assign q_pop      = (state_reg == B_IDLE) && !q_stat.empty && out_free;
    assign head_mem   = q_pop && (q_head.kind == KIND_LOOKUP || q_head.kind == KIND_FILL);
    assign head_other = q_pop && !head_mem;
    assign exec       = (state_reg == B_EXEC);
    assign rd_addr    = q_head.set_idx[SET_W-1:0];

    // Way compare, first hit and fill victim choice
    always_comb begin
        hit_any  = 1'b0;
        hit_desc = '0;
        pick     = op_reg.way_idx[WAY_W-1:0];
        for (int w = 0; w < WAY_COUNT; w++) begin
            live[w]  = (rd_data[w].gen == frame_gen_reg);
            match[w] = live[w] && (rd_data[w].object_key == op_reg.object_key)
                       && (rd_data[w].index_key == op_reg.index_key);
        end
        for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_any  = 1'b1;
                hit_desc = rd_data[w].descriptor;
            end
            if (!live[w]) begin
                pick = WAY_W'(w);
            end
        end
        all_live = &live;
    end

    // Write port: clearing pass or fill
    always_comb begin
        wr_addr = clear_busy ? clr_cnt_reg : op_reg.set_idx[SET_W-1:0];
        if (clear_busy) begin
            wr_data = '0;
        end else begin
            wr_data.gen        = frame_gen_reg;
            wr_data.object_key = op_reg.object_key;
            wr_data.index_key  = op_reg.index_key;
            wr_data.descriptor = op_reg.fill_descriptor;
        end
        for (int w = 0; w < WAY_COUNT; w++) begin
            wr_en[w] = clear_busy
                       || (exec && op_reg.kind == KIND_FILL && pick == WAY_W'(w));
        end
    end

    // One memory per way, shared read address
    for (genvar w = 0; w < WAY_COUNT; w++) begin : g_way
        gtc_entry_t mem [SET_COUNT];
        gtc_entry_t rd_reg;

        always_ff @(posedge aclk) begin
            if (wr_en[w]) begin
                mem[wr_addr] <= wr_data;
            end
            if (head_mem) begin
                rd_reg <= mem[rd_addr];
            end
        end

        assign rd_data[w] = rd_reg;
    end

    // Generation advance skips zero
    assign gen_inc = frame_gen_reg + 32'd1;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        frame_gen_next = frame_gen_reg;
        m_valid_next   = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            B_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == SET_LAST) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (head_mem) begin
                    state_next = B_EXEC;
                end else if (head_other) begin
                    m_valid_next = 1'b1;
                    if (q_head.kind == KIND_TICK) begin
                        frame_gen_next = (gen_inc == 32'd0) ? 32'd1 : gen_inc;
                    end
                end
            end
            B_EXEC: begin
                m_valid_next = 1'b1;
                state_next   = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            frame_gen_reg <= 32'd1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            frame_gen_reg <= frame_gen_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Operation and result payload
    always_ff @(posedge aclk) begin
        if (head_mem) begin
            op_reg <= q_head;
        end
        if (head_other) begin
            m_hit_reg  <= 1'b0;
            m_desc_reg <= '0;
            m_disp_reg <= 1'b0;
        end else if (exec) begin
            if (op_reg.kind == KIND_FILL) begin
                m_hit_reg  <= 1'b0;
                m_desc_reg <= op_reg.fill_descriptor;
                m_disp_reg <= all_live;
            end else begin
                m_hit_reg  <= hit_any;
                m_desc_reg <= hit_desc;
                m_disp_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_hit            = m_hit_reg;
    assign m_descriptor_out = m_desc_reg;
    assign m_displaced      = m_disp_reg;

endmodule

`default_nettype wire

// ===== rtl/generation_tagged_two_way_cache_core.sv =====
// Channel   Dir  Handshake          Beat contents
// s_*       in   s_valid/s_ready    kind, object_key, index_key, fill_descriptor
// m_*       out  m_valid/m_ready    hit, descriptor_out, displaced
//
// Front end takes one beat at a time, through a registered hash multiply, fold and queue
// push; when SET_COUNT or WAY_COUNT is not a power of two a reciprocal remainder is added.
// Back end: a lookup or fill takes a registered memory read, then compare and write; a
// frame tick needs no memory access; a 2-entry queue decouples the two sides.
// After reset a clearing pass over all SET_COUNT sets zeroes the generation stamps;
// s_ready stays low during it. m_ready low stalls the back end; the front end
// stalls once the queue is full.
`default_nettype none
`include "generation_tagged_two_way_cache_core_defines.svh"

module generation_tagged_two_way_cache_core #(
    parameter int SET_COUNT = 8192,
    parameter int WAY_COUNT = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [31:0] s_object_key,
    input  wire logic [31:0] s_index_key,
    input  wire logic [31:0] s_fill_descriptor,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_hit,
    output logic [31:0]      m_descriptor_out,
    output logic             m_displaced
);
    import gtc_pkg::*;

    logic        clear_busy;
    logic        q_push, q_pop;
    gtc_op_t     q_op, q_head;
    gtc_q_stat_t q_stat;

    // Hash and classify
    gtc_front #(
        .SET_COUNT (SET_COUNT),
        .WAY_COUNT (WAY_COUNT)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_object_key      (s_object_key),
        .s_index_key       (s_index_key),
        .s_fill_descriptor (s_fill_descriptor),
        .clear_busy        (clear_busy),
        .q_stat            (q_stat),
        .q_push            (q_push),
        .q_op              (q_op)
    );

    // Decoupling queue
    gtc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (q_op),
        .pop     (q_pop),
        .head_op (q_head),
        .stat    (q_stat)
    );

    // Cache array and result
    gtc_back #(
        .SET_COUNT (SET_COUNT),
        .WAY_COUNT (WAY_COUNT)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_stat           (q_stat),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .clear_busy       (clear_busy),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hit            (m_hit),
        .m_descriptor_out (m_descriptor_out),
        .m_displaced      (m_displaced)
    );

    // Checks
    `GTC_ASSERT_NEVER(a_push_full, aclk, aresetn, q_push && q_stat.full, "push into full queue")
    `GTC_ASSERT_NEVER(a_pop_empty, aclk, aresetn, q_pop && q_stat.empty, "pop from empty queue")
    `GTC_ASSERT_IMPLY(a_clear_quiet, aclk, aresetn, clear_busy, !m_valid && !s_ready && !q_pop)
    `GTC_ASSERT_IMPLY(a_hit_no_disp, aclk, aresetn, m_valid && m_hit, !m_displaced)

endmodule

`default_nettype wire
